FILE: rtl/rts_pkg.sv
// Shared constants for the residual trim and select block.
`timescale 1ns / 1ps
package rts_pkg;
	localparam int CAPACITY_DEF = 64;
	localparam int RES_W = 32;
	localparam int ID_W = 16;
	localparam int GAIN_W = 16;
	localparam int FRAC_W = 17;
	localparam int RANK_W = 6;
	localparam int ENTRY_W = RES_W + ID_W;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
	localparam int REG_GAIN = 0;
	localparam int REG_FRAC = 1;
endpackage

FILE: rtl/rts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module rts_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/rts_isqrt.sv
// Iterative 64-bit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module rts_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic [63:0] trial;
	assign trial = res_q + bit_q;
	assign root  = res_q[31:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= !start && busy_q && bit_q == 64'd0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd0) begin
				busy_q <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= value;
			res_q <= 64'd0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q && bit_q != 64'd0) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
endmodule

FILE: rtl/residual_trim_select.sv
// Residual trim and select top level: store, statistics, partition, quickselect, emit.
// Sequence: loading takes one item per cycle. After the last item, if the gain is nonzero,
// come the sum pass, mean and variance divisions, square root and threshold and a trim pass;
// then quickselect (pivot placement, compares, swaps) when the fraction applies, then results.
// Throughput: one set at a time; in_ready stays low from the last item to the last result.
// Reset clears the state, config registers, counts and out_valid; data registers and the entry RAM are not cleared.
`timescale 1ns / 1ps
module residual_trim_select import rts_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [FRAC_W-1:0]     cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [RES_W-1:0]      residual,
	input  logic [ID_W-1:0]       pair_id,
	input  logic                  is_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ID_W-1:0]       out_pair_id,
	output logic [RES_W-1:0]      out_residual,
	output logic [RANK_W-1:0]     rank,
	output logic                  end_of_run,
	output logic                  dropped_items
);
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [20:0] {
		ST_LOAD   = 21'h000001, ST_SUM    = 21'h000002, ST_VAR    = 21'h000004,
		ST_DIV    = 21'h000008, ST_SQRT   = 21'h000010, ST_THR    = 21'h000020,
		ST_TRD    = 21'h000040, ST_TRC    = 21'h000080, ST_SWA    = 21'h000100,
		ST_SWB    = 21'h000200, ST_FRAC   = 21'h000400, ST_QPIV   = 21'h000800,
		ST_QRD    = 21'h001000, ST_QCMP   = 21'h002000, ST_SWW1   = 21'h004000,
		ST_SWW2   = 21'h008000, ST_QEND   = 21'h010000, ST_EMIT   = 21'h020000,
		ST_EWAIT  = 21'h040000, ST_MUL    = 21'h080000, ST_SWR    = 21'h100000
	} state_t;

	typedef enum logic [1:0] {RET_TRIM, RET_QPIV, RET_QLOOP, RET_QEND} ret_t;

	state_t st_q;
	ret_t   ret_q;
	logic [GAIN_W-1:0] gain_q;
	logic [FRAC_W-1:0] frac_q;
	logic [CW-1:0] cnt_q, n_q, kept_q;
	logic ovf_q, drop_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;
	rts_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic [RES_W-1:0] rd_res;
	assign rd_res = rdata[ENTRY_W-1:ID_W];

	// statistics
	logic [CW-1:0] idx_q;
	logic          rdv_q;
	logic [37:0]   sum_q;
	logic [31:0]   mean_q;
	logic [69:0]   sq_q;
	logic [63:0]   dq_q;
	logic [6:0]    dcnt_q;
	logic [69:0]   drem_q;
	logic          div_mean_q;
	logic [6:0]    dbit;
	logic [69:0]   dsum;
	logic [31:0]   dev_abs;
	logic [63:0]   dev_sq;
	logic [40:0]   t_q;
	logic [47:0]   gs_q;
	logic          sq_start, sq_done;
	logic [31:0]   sq_root;
	logic [69:0]   dtrial;
	logic          rdelay_q;

	rts_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .value(dq_q),
		.done(sq_done), .root(sq_root)
	);

	assign dev_abs = (rd_res >= mean_q) ? rd_res - mean_q : mean_q - rd_res;
	assign dev_sq  = dev_abs * dev_abs;
	assign dtrial  = {drem_q[68:0], 1'b0};
	assign dbit    = dcnt_q - 7'd1;
	assign dsum    = dtrial + 70'(sq_q[dbit]);

	// swap engine: a and b addresses, held entries
	logic [AW-1:0] sa_q, sb_q;
	logic [ENTRY_W-1:0] ea_q, eb_q;
	logic [CW-1:0] sel_q;
	logic [CW-1:0] left_q, right_q, last_q, k_q, h_q;
	logic [RES_W-1:0] piv_q;
	logic [CW+16:0] hprod;
	logic [CW-1:0] mid;

	assign hprod = frac_q * n_q;
	assign mid   = CW'((CW+1)'(left_q) + (CW+1)'(right_q) >> 1);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = idx_q[AW-1:0];
		case (st_q)
			ST_LOAD: begin
				we    = in_valid && cnt_q != CAP_C;
				waddr = cnt_q[AW-1:0];
				wdata = {residual, pair_id};
			end
			ST_SWR: raddr = sa_q;
			ST_SWA: raddr = sb_q;
			ST_SWW1: begin
				we = 1'b1; waddr = sa_q; wdata = eb_q;
			end
			ST_SWW2: begin
				we = 1'b1; waddr = sb_q; wdata = ea_q;
			end
			default: ;
		endcase
	end

	assign in_ready = (st_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_LOAD;
			gain_q    <= '0;
			frac_q    <= '0;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
			rdv_q     <= 1'b0;
			ret_q     <= RET_TRIM;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(REG_GAIN)) begin
					gain_q <= cfg_data[GAIN_W-1:0];
				end else begin
					frac_q <= cfg_data;
				end
			end
			// read issued this cycle, data valid the next
			rdv_q <= (st_q == ST_SUM || st_q == ST_VAR) && idx_q != n_q;
			case (st_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (is_last) begin
							n_q    <= (cnt_q != CAP_C) ? cnt_q + 1'b1 : cnt_q;
							kept_q <= (cnt_q != CAP_C) ? cnt_q + 1'b1 : cnt_q;
							drop_q <= ovf_q || cnt_q == CAP_C;
							cnt_q  <= '0;
							ovf_q  <= 1'b0;
							idx_q  <= '0;
							sum_q  <= '0;
							if (gain_q != '0) begin
								st_q <= ST_SUM;
							end else begin
								st_q <= ST_FRAC;
							end
						end else if (cnt_q != CAP_C) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SUM: begin
					// read one per cycle, accumulate in the cycle after
					if (idx_q != n_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rdv_q) begin
						sum_q <= sum_q + 38'(rd_res);
					end
					if (idx_q == n_q && !rdv_q) begin
						// divide the sum by the count to get the mean
						idx_q      <= '0;
						sq_q       <= 70'(sum_q);
						drem_q     <= '0;
						dq_q       <= '0;
						dcnt_q     <= 7'd70;
						div_mean_q <= 1'b1;
						st_q       <= ST_DIV;
					end
				end
				ST_VAR: begin
					if (idx_q != n_q) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rdv_q) begin
						sq_q <= sq_q + 70'(dev_sq);
					end
					if (idx_q == n_q && !rdv_q) begin
						drem_q     <= '0;
						dq_q       <= '0;
						dcnt_q     <= 7'd70;
						div_mean_q <= 1'b0;
						st_q       <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if (dcnt_q != '0) begin
						dcnt_q <= dcnt_q - 1'b1;
						if (dsum >= 70'(n_q)) begin
							drem_q <= dsum - 70'(n_q);
							dq_q   <= {dq_q[62:0], 1'b1};
						end else begin
							drem_q <= dsum;
							dq_q   <= {dq_q[62:0], 1'b0};
						end
					end else if (div_mean_q) begin
						mean_q <= dq_q[31:0];
						sq_q   <= '0;
						st_q   <= ST_VAR;
					end else begin
						st_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (sq_done) begin
						gs_q <= gain_q * sq_root;
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					t_q   <= 41'(mean_q) + 41'(gs_q[47:8]);
					sel_q <= n_q;
					idx_q <= '0;
					st_q  <= ST_TRD;
				end
				ST_TRD: begin
					if (idx_q >= sel_q) begin
						kept_q <= sel_q;
						st_q   <= ST_FRAC;
					end else begin
						st_q <= ST_TRC;
					end
				end
				ST_TRC: begin
					if (rdelay_q) begin
						if (41'(rd_res) > t_q) begin
							sa_q  <= idx_q[AW-1:0];
							sb_q  <= AW'(sel_q - 1'b1);
							sel_q <= sel_q - 1'b1;
							ret_q <= RET_TRIM;
							st_q  <= ST_SWR;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= ST_TRD;
						end
					end
				end
				ST_SWR: st_q <= ST_SWA;
				ST_SWA: begin
					ea_q <= rdata;
					st_q <= ST_SWB;
				end
				ST_SWB: begin
					eb_q <= rdata;
					st_q <= ST_SWW1;
				end
				ST_SWW1: st_q <= ST_SWW2;
				ST_SWW2: begin
					case (ret_q)
						RET_TRIM: st_q <= ST_TRD;
						RET_QPIV: begin
							last_q <= left_q;
							k_q    <= left_q + 1'b1;
							idx_q  <= left_q;
							st_q   <= ST_QPIV;
						end
						RET_QLOOP: begin
							k_q  <= k_q + 1'b1;
							st_q <= ST_QRD;
						end
						default: begin
							if (last_q > h_q) begin
								right_q <= last_q - 1'b1;
								st_q    <= ST_QEND;
							end else if (last_q < h_q) begin
								left_q <= last_q + 1'b1;
								st_q   <= ST_QEND;
							end else begin
								idx_q <= '0;
								st_q  <= ST_EMIT;
							end
						end
					endcase
				end
				ST_FRAC: begin
					h_q <= CW'(hprod >> 16);
					if (frac_q != '0 && frac_q < FRAC_ONE
							&& CW'(hprod >> 16) != '0 && CW'(hprod >> 16) < kept_q) begin
						left_q  <= '0;
						right_q <= kept_q - 1'b1;
						kept_q  <= CW'(hprod >> 16);
						st_q    <= ST_QEND;
					end else begin
						idx_q <= '0;
						st_q  <= ST_EMIT;
					end
				end
				ST_QEND: begin
					// start a partition: swap middle to left
					sa_q  <= left_q[AW-1:0];
					sb_q  <= mid[AW-1:0];
					ret_q <= RET_QPIV;
					st_q  <= ST_SWR;
				end
				ST_QPIV: begin
					if (rdelay_q) begin
						piv_q <= rd_res;
						st_q  <= ST_QRD;
					end
				end
				ST_QRD: begin
					if (k_q > right_q) begin
						sa_q  <= left_q[AW-1:0];
						sb_q  <= last_q[AW-1:0];
						ret_q <= RET_QEND;
						st_q  <= ST_SWR;
					end else begin
						idx_q <= k_q;
						st_q  <= ST_QCMP;
					end
				end
				ST_QCMP: begin
					if (rdelay_q) begin
						if (rd_res < piv_q) begin
							last_q <= last_q + 1'b1;
							sa_q   <= k_q[AW-1:0];
							sb_q   <= AW'(last_q + 1'b1);
							ret_q  <= RET_QLOOP;
							st_q   <= ST_SWR;
						end else begin
							k_q  <= k_q + 1'b1;
							st_q <= ST_QRD;
						end
					end
				end
				ST_EMIT: begin
					if (rdelay_q) begin
						out_valid     <= 1'b1;
						out_pair_id   <= rdata[ID_W-1:0];
						out_residual  <= rd_res;
						rank          <= RANK_W'(idx_q);
						end_of_run    <= (idx_q == kept_q - 1'b1);
						dropped_items <= drop_q;
						st_q          <= ST_EWAIT;
					end
				end
				ST_EWAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (end_of_run) begin
							st_q <= ST_LOAD;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= ST_EMIT;
						end
					end
				end
				default: st_q <= ST_LOAD;
			endcase
		end
	end

	// read delay flag for states that read at idx_q, waiting out the registered RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdelay_q <= 1'b0;
		end else begin
			rdelay_q <= (st_q == ST_TRC || st_q == ST_QPIV || st_q == ST_QCMP
				|| st_q == ST_EMIT) && !rdelay_q;
		end
	end

	assign sq_start = (st_q == ST_DIV) && dcnt_q == '0 && !div_mean_q;

	ap_ready_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input taken while emitting");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rank))
		else $error("result changed while stalled");
	ap_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C) else $error("count beyond capacity");
	ap_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kept_q != '0 && kept_q <= n_q) else $error("bad kept count");
endmodule
